@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, constants and codes of the priority task table.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int MAX_TASKS = 16;
   localparam int TAG_BITS  = 16;

   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int PRIO_W    = 3;
   localparam int TAG_IN_W  = 16;
   localparam int POS_W     = 5;
   localparam int COUNT_W   = 5;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [PRIO_W-1:0]   prio_type;
   typedef logic [TAG_BITS-1:0] tag_type;
   typedef logic [TAG_IN_W-1:0] tag_port_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [COUNT_W-1:0]  count_port_type;

   localparam prio_type PRIO_MIN = 3'd1;
   localparam prio_type PRIO_MAX = 3'd5;

   typedef struct packed {
      prio_type prio;
      tag_type  tag;
   } entry_type;

   typedef enum logic [1:0] {
      ACT_CREATE = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_SORT   = 2'd2,
      ACT_LIST   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_PRIO = 2'd1,
      STATUS_BAD_POS  = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CREATE,
      OP_BAD_POS,
      OP_DEL_INIT,
      OP_DEL_READ,
      OP_DEL_MOVE,
      OP_DEL_DONE,
      OP_SORT_INIT,
      OP_OUTER_READ,
      OP_CUR_LOAD,
      OP_INNER_READ,
      OP_OUTER_DONE,
      OP_COMPARE,
      OP_LIST_INIT,
      OP_LIST_EMPTY,
      OP_LIST_READ,
      OP_LIST_EMIT
   } dp_op_type;

   typedef struct packed {
      action_type action;
      logic       pos_ok;
      logic       count_zero;
      logic       i_more;
      logic       j_more;
      logic       list_last;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DEL_CHECK,
      ST_DEL_MOVE,
      ST_SORT_OUTER,
      ST_SORT_LOAD,
      ST_SORT_INNER,
      ST_SORT_CMP,
      ST_LIST_START,
      ST_LIST_READ,
      ST_LIST_EMIT
   } ctl_state_type;

endpackage

@@ rtl/ptt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer of the priority task table: steps create, delete, sort and list.
// ----------------------------------------------------------------------------
module ptt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ptt_pkg::dp_status_type status,
   output ptt_pkg::dp_op_type     op,
   output logic                   busy
);

   ptt_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (start) state_in = ptt_pkg::ST_DISPATCH;
         end
         ptt_pkg::ST_DISPATCH: begin
            unique case (status.action)
               ptt_pkg::ACT_CREATE: state_in = ptt_pkg::ST_IDLE;
               ptt_pkg::ACT_DELETE: begin
                  state_in = status.pos_ok ? ptt_pkg::ST_DEL_CHECK : ptt_pkg::ST_IDLE;
               end
               ptt_pkg::ACT_SORT:   state_in = ptt_pkg::ST_SORT_OUTER;
               ptt_pkg::ACT_LIST:   state_in = ptt_pkg::ST_LIST_START;
               default:             state_in = ptt_pkg::ST_IDLE;
            endcase
         end
         ptt_pkg::ST_DEL_CHECK: begin
            state_in = status.i_more ? ptt_pkg::ST_DEL_MOVE : ptt_pkg::ST_IDLE;
         end
         ptt_pkg::ST_DEL_MOVE:   state_in = ptt_pkg::ST_DEL_CHECK;
         ptt_pkg::ST_SORT_OUTER: begin
            state_in = status.i_more ? ptt_pkg::ST_SORT_LOAD : ptt_pkg::ST_LIST_START;
         end
         ptt_pkg::ST_SORT_LOAD:  state_in = ptt_pkg::ST_SORT_INNER;
         ptt_pkg::ST_SORT_INNER: begin
            state_in = status.j_more ? ptt_pkg::ST_SORT_CMP : ptt_pkg::ST_SORT_OUTER;
         end
         ptt_pkg::ST_SORT_CMP:   state_in = ptt_pkg::ST_SORT_INNER;
         ptt_pkg::ST_LIST_START: begin
            state_in = status.count_zero ? ptt_pkg::ST_IDLE : ptt_pkg::ST_LIST_READ;
         end
         ptt_pkg::ST_LIST_READ:  state_in = ptt_pkg::ST_LIST_EMIT;
         ptt_pkg::ST_LIST_EMIT: begin
            state_in = status.list_last ? ptt_pkg::ST_IDLE : ptt_pkg::ST_LIST_READ;
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op   = ptt_pkg::OP_NONE;
      busy = (state_ff != ptt_pkg::ST_IDLE);
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (start) op = ptt_pkg::OP_LOAD;
         end
         ptt_pkg::ST_DISPATCH: begin
            unique case (status.action)
               ptt_pkg::ACT_CREATE: op = ptt_pkg::OP_CREATE;
               ptt_pkg::ACT_DELETE: begin
                  op = status.pos_ok ? ptt_pkg::OP_DEL_INIT : ptt_pkg::OP_BAD_POS;
               end
               ptt_pkg::ACT_SORT:   op = ptt_pkg::OP_SORT_INIT;
               ptt_pkg::ACT_LIST:   op = ptt_pkg::OP_NONE;
               default:             op = ptt_pkg::OP_NONE;
            endcase
         end
         ptt_pkg::ST_DEL_CHECK: begin
            op = status.i_more ? ptt_pkg::OP_DEL_READ : ptt_pkg::OP_DEL_DONE;
         end
         ptt_pkg::ST_DEL_MOVE:   op = ptt_pkg::OP_DEL_MOVE;
         ptt_pkg::ST_SORT_OUTER: begin
            op = status.i_more ? ptt_pkg::OP_OUTER_READ : ptt_pkg::OP_NONE;
         end
         ptt_pkg::ST_SORT_LOAD:  op = ptt_pkg::OP_CUR_LOAD;
         ptt_pkg::ST_SORT_INNER: begin
            op = status.j_more ? ptt_pkg::OP_INNER_READ : ptt_pkg::OP_OUTER_DONE;
         end
         ptt_pkg::ST_SORT_CMP:   op = ptt_pkg::OP_COMPARE;
         ptt_pkg::ST_LIST_START: begin
            op = status.count_zero ? ptt_pkg::OP_LIST_EMPTY : ptt_pkg::OP_LIST_INIT;
         end
         ptt_pkg::ST_LIST_READ:  op = ptt_pkg::OP_LIST_READ;
         ptt_pkg::ST_LIST_EMIT:  op = ptt_pkg::OP_LIST_EMIT;
         default:                op = ptt_pkg::OP_NONE;
      endcase
   end

endmodule

@@ rtl/ptt_datapath.sv @@
// ----------------------------------------------------------------------------
// ptt_datapath
// Entry memory, count, loop indexes, held entry and result registers.
// ----------------------------------------------------------------------------
module ptt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_action,
   input  ptt_pkg::prio_type             req_priority_req,
   input  ptt_pkg::tag_port_type         req_tag,
   input  ptt_pkg::pos_type              req_position,
   input  ptt_pkg::dp_op_type            op,
   output ptt_pkg::dp_status_type        status,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_entry_valid,
   output ptt_pkg::pos_type              rsp_entry_position,
   output ptt_pkg::prio_type             rsp_entry_priority,
   output ptt_pkg::tag_port_type         rsp_entry_tag,
   output ptt_pkg::count_port_type       rsp_count,
   output logic                          rsp_last
);

   ptt_pkg::entry_type mem [ptt_pkg::MAX_TASKS];

   ptt_pkg::action_type   action_ff;
   ptt_pkg::prio_type     prio_ff;
   ptt_pkg::tag_type      tag_ff;
   ptt_pkg::pos_type      pos_ff;
   ptt_pkg::cnt_type      count_ff, count_in;
   ptt_pkg::cnt_type      i_ff, i_in;
   ptt_pkg::cnt_type      j_ff, j_in;
   ptt_pkg::entry_type    cur_ff, cur_in;
   ptt_pkg::entry_type    rd_data_ff;

   logic                  rsp_strobe_ff;
   ptt_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ptt_pkg::pos_type      rsp_pos_ff, rsp_pos_in;
   ptt_pkg::prio_type     rsp_prio_ff, rsp_prio_in;
   ptt_pkg::tag_port_type rsp_tag_ff, rsp_tag_in;
   ptt_pkg::count_port_type rsp_count_ff;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_emit;

   logic                  wr_en;
   ptt_pkg::idx_type      wr_addr;
   ptt_pkg::entry_type    wr_data;
   logic                  rd_en;
   ptt_pkg::idx_type      rd_addr;

   ptt_pkg::cnt_type      i_next1;
   ptt_pkg::entry_type    new_entry;
   logic                  prio_ok;
   logic                  full;
   logic                  swap;

   assign i_next1   = i_ff + ptt_pkg::cnt_type'(1);
   assign prio_ok   = (prio_ff >= ptt_pkg::PRIO_MIN) && (prio_ff <= ptt_pkg::PRIO_MAX);
   assign full      = (count_ff == ptt_pkg::cnt_type'(ptt_pkg::MAX_TASKS));
   assign swap      = (cur_ff.prio < rd_data_ff.prio);

   always_comb begin
      new_entry.prio = prio_ff;
      new_entry.tag  = tag_ff;
   end

   always_comb begin
      status.action     = action_ff;
      status.pos_ok     = (pos_ff != '0) && (32'(pos_ff) <= 32'(count_ff));
      status.count_zero = (count_ff == '0);
      status.i_more     = (i_next1 < count_ff);
      status.j_more     = (j_ff < count_ff);
      status.list_last  = (i_next1 == count_ff);
   end

   always_comb begin
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cur_in        = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff[ptt_pkg::IDX_W-1:0];
      wr_data       = rd_data_ff;
      rd_en         = 1'b0;
      rd_addr       = i_ff[ptt_pkg::IDX_W-1:0];
      rsp_emit      = 1'b0;
      rsp_status_in = ptt_pkg::STATUS_OK;
      rsp_valid_in  = 1'b0;
      rsp_pos_in    = '0;
      rsp_prio_in   = '0;
      rsp_tag_in    = '0;
      rsp_last_in   = 1'b1;
      unique case (op)
         ptt_pkg::OP_NONE, ptt_pkg::OP_LOAD: begin
         end
         ptt_pkg::OP_CREATE: begin
            rsp_emit = 1'b1;
            if (!prio_ok) begin
               rsp_status_in = ptt_pkg::STATUS_BAD_PRIO;
            end else if (full) begin
               rsp_status_in = ptt_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[ptt_pkg::IDX_W-1:0];
               wr_data  = new_entry;
               count_in = count_ff + ptt_pkg::cnt_type'(1);
            end
         end
         ptt_pkg::OP_BAD_POS: begin
            rsp_emit      = 1'b1;
            rsp_status_in = ptt_pkg::STATUS_BAD_POS;
         end
         ptt_pkg::OP_DEL_INIT: begin
            i_in = ptt_pkg::cnt_type'(pos_ff) - ptt_pkg::cnt_type'(1);
         end
         ptt_pkg::OP_DEL_READ: begin
            rd_en   = 1'b1;
            rd_addr = i_next1[ptt_pkg::IDX_W-1:0];
         end
         ptt_pkg::OP_DEL_MOVE: begin
            wr_en = 1'b1;
            i_in  = i_next1;
         end
         ptt_pkg::OP_DEL_DONE: begin
            rsp_emit = 1'b1;
            count_in = count_ff - ptt_pkg::cnt_type'(1);
         end
         ptt_pkg::OP_SORT_INIT: begin
            i_in = '0;
         end
         ptt_pkg::OP_OUTER_READ: begin
            rd_en = 1'b1;
            j_in  = i_next1;
         end
         ptt_pkg::OP_CUR_LOAD: begin
            cur_in = rd_data_ff;
         end
         ptt_pkg::OP_INNER_READ: begin
            rd_en   = 1'b1;
            rd_addr = j_ff[ptt_pkg::IDX_W-1:0];
         end
         ptt_pkg::OP_OUTER_DONE: begin
            wr_en   = 1'b1;
            wr_data = cur_ff;
            i_in    = i_next1;
         end
         ptt_pkg::OP_COMPARE: begin
            if (swap) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[ptt_pkg::IDX_W-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            j_in = j_ff + ptt_pkg::cnt_type'(1);
         end
         ptt_pkg::OP_LIST_INIT: begin
            i_in = '0;
         end
         ptt_pkg::OP_LIST_EMPTY: begin
            rsp_emit = 1'b1;
         end
         ptt_pkg::OP_LIST_READ: begin
            rd_en = 1'b1;
         end
         ptt_pkg::OP_LIST_EMIT: begin
            rsp_emit     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_pos_in   = ptt_pkg::pos_type'(i_next1);
            rsp_prio_in  = rd_data_ff.prio;
            rsp_tag_in   = ptt_pkg::tag_port_type'(rd_data_ff.tag);
            rsp_last_in  = (i_next1 == count_ff);
            i_in         = i_next1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_emit;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
      if (op == ptt_pkg::OP_LOAD) begin
         action_ff <= ptt_pkg::action_type'(req_action);
         prio_ff   <= req_priority_req;
         tag_ff    <= ptt_pkg::tag_type'(req_tag);
         pos_ff    <= req_position;
      end
      if (rsp_emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_count_ff  <= ptt_pkg::count_port_type'(count_in);
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_valid    = rsp_valid_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_priority = rsp_prio_ff;
   assign rsp_entry_tag      = rsp_tag_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ rtl/priority_task_table.sv @@
// ----------------------------------------------------------------------------
// priority_task_table
// Table of prioritized tasks with create, delete, exchange sort and listing.
//
//   channel   ports                 transfer
//   request   start, busy, req_*    start high while busy is low
//   result    rsp_strobe, rsp_*     one cycle per result, strobe marks it
//
// Create and a rejected delete: the request is registered at start, the dispatch
// state decides, and its result is registered onto the rsp_* ports. Delete at
// position p: each entry after p is read and then written one place lower. List:
// each entry is read through the memory port and then emitted as its own result.
// Sort runs before a list; each compare-swap step is a read on the one port.
// Synchronous reset empties the table; results cannot be stalled.
// ----------------------------------------------------------------------------
module priority_task_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_priority_req,
   input  logic [15:0] req_tag,
   input  logic [4:0]  req_position,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic        rsp_entry_valid,
   output logic [4:0]  rsp_entry_position,
   output logic [2:0]  rsp_entry_priority,
   output logic [15:0] rsp_entry_tag,
   output logic [4:0]  rsp_count,
   output logic        rsp_last
);

   ptt_pkg::dp_op_type     op;
   ptt_pkg::dp_status_type status;

   ptt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   ptt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_action),
      .req_priority_req   (req_priority_req),
      .req_tag            (req_tag),
      .req_position       (req_position),
      .op                 (op),
      .status             (status),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_priority (rsp_entry_priority),
      .rsp_entry_tag      (rsp_entry_tag),
      .rsp_count          (rsp_count),
      .rsp_last           (rsp_last)
   );

endmodule

@@ rtl/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the priority task table, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic        rsp_entry_valid,
   input logic [4:0]  rsp_entry_position,
   input logic [4:0]  rsp_count,
   input logic        rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy after final result");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("idle with results outstanding");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_entry_valid) |-> rsp_last)
      else $error("status result not final");

   a_list_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_valid && rsp_last) |->
         (rsp_entry_position == rsp_count) && (rsp_status == ptt_pkg::STATUS_OK))
      else $error("final listed entry does not match count");

endmodule

bind priority_task_table ptt_checker u_ptt_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_entry_valid    (rsp_entry_valid),
   .rsp_entry_position (rsp_entry_position),
   .rsp_count          (rsp_count),
   .rsp_last           (rsp_last)
);
